// ===== src/rlp_pkg.sv =====
// Shared types, codes and constants for the RLP header stream parser.
`timescale 1ns / 1ps

package rlp_pkg;

  // Default for the widest accepted run of big-endian length bytes.
  localparam int LEN_BYTES_MAX_DEF = 2;
  localparam int LLEN_W            = 4;
  localparam int SHORT_LEN_W       = 6;

  // Queue depths between the parts of the block.
  localparam int HDR_DEPTH = 4;
  localparam int RES_DEPTH = 4;

  // Header byte boundaries.
  localparam logic [7:0] SINGLE_MAX     = 8'h7F;
  localparam logic [7:0] STR_BASE       = 8'h80;
  localparam logic [7:0] STR_SHORT_MAX  = 8'hB7;
  localparam logic [7:0] STR_LONG_MAX   = 8'hBF;
  localparam logic [7:0] LIST_BASE      = 8'hC0;
  localparam logic [7:0] LIST_SHORT_MAX = 8'hF7;
  localparam logic [7:0] BYTE_MAX       = 8'hFF;

  // Header classes.
  localparam logic [2:0] CL_SINGLE     = 3'd0;
  localparam logic [2:0] CL_SHORT_STR  = 3'd1;
  localparam logic [2:0] CL_LONG_STR   = 3'd2;
  localparam logic [2:0] CL_SHORT_LIST = 3'd3;
  localparam logic [2:0] CL_LONG_LIST  = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_RECORD  = 2'd0;
  localparam logic [1:0] ST_SUMMARY = 2'd1;
  localparam logic [1:0] ST_ERROR   = 2'd2;

  // Item kinds.
  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_STRING = 2'd1;
  localparam logic [1:0] KIND_LIST   = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  item_kind;
    logic [15:0] value_length;
    logic [1:0]  value_offset;
    logic [15:0] field_start;
    logic [7:0]  field_count;
    logic        last_of_run;
  } res_word_t;

  // A classified byte as it waits between the front and the back.
  typedef struct packed {
    logic [7:0]             data_byte;
    logic                   last_byte;
    logic [2:0]             hclass;
    logic [SHORT_LEN_W-1:0] short_len;
    logic [LLEN_W-1:0]      len_bytes;
    logic                   too_long;
  } hdr_t;

  // Handshake between the back and the result queue.
  typedef struct packed {
    logic wr0;
    logic wr1;
  } res_wr_t;

endpackage

// ===== src/rlp_front.sv =====
// Front part: classifies each incoming byte and queues it for the parser.
`timescale 1ns / 1ps

module rlp_front #(
  parameter int LENGTH_BYTES_MAX = rlp_pkg::LEN_BYTES_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  rlp_pkg::in_word_t item,
  output rlp_pkg::hdr_t     head,
  output logic              head_valid,
  input  logic              head_pop
);

  localparam int DEPTH = rlp_pkg::HDR_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  rlp_pkg::hdr_t mem [DEPTH];
  rlp_pkg::hdr_t cls;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic push_ok;
  logic pop_ok;
  logic [7:0] str_diff;
  logic [7:0] list_diff;
  logic [7:0] str_ll;
  logic [7:0] list_ll;

  assign str_diff  = item.data_byte - rlp_pkg::STR_BASE;
  assign list_diff = item.data_byte - rlp_pkg::LIST_BASE;
  assign str_ll    = item.data_byte - rlp_pkg::STR_SHORT_MAX;
  assign list_ll   = item.data_byte - rlp_pkg::LIST_SHORT_MAX;

  always_comb begin
    cls.data_byte = item.data_byte;
    cls.last_byte = item.last_byte;
    cls.short_len = '0;
    cls.len_bytes = '0;
    priority if (item.data_byte <= rlp_pkg::SINGLE_MAX) begin
      cls.hclass = rlp_pkg::CL_SINGLE;
    end else if (item.data_byte <= rlp_pkg::STR_SHORT_MAX) begin
      cls.hclass    = rlp_pkg::CL_SHORT_STR;
      cls.short_len = str_diff[rlp_pkg::SHORT_LEN_W-1:0];
    end else if (item.data_byte <= rlp_pkg::STR_LONG_MAX) begin
      cls.hclass    = rlp_pkg::CL_LONG_STR;
      cls.len_bytes = str_ll[rlp_pkg::LLEN_W-1:0];
    end else if (item.data_byte <= rlp_pkg::LIST_SHORT_MAX) begin
      cls.hclass    = rlp_pkg::CL_SHORT_LIST;
      cls.short_len = list_diff[rlp_pkg::SHORT_LEN_W-1:0];
    end else begin
      cls.hclass    = rlp_pkg::CL_LONG_LIST;
      cls.len_bytes = list_ll[rlp_pkg::LLEN_W-1:0];
    end
    cls.too_long = (cls.len_bytes > rlp_pkg::LLEN_W'(LENGTH_BYTES_MAX));
  end

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign push_ok    = push && !full;
  assign pop_ok     = head_pop && head_valid;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push_ok) - CNT_W'(pop_ok);
    end
  end

endmodule

// ===== src/rlp_back.sv =====
// Back part: the parse state machine that turns classified bytes into results.
`timescale 1ns / 1ps

module rlp_back #(
  parameter int LENGTH_BYTES_MAX = rlp_pkg::LEN_BYTES_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data,
  input  rlp_pkg::hdr_t      head,
  input  logic               head_valid,
  output logic               head_pop,
  input  logic               room,
  output rlp_pkg::res_wr_t   wr,
  output rlp_pkg::res_word_t res0,
  output rlp_pkg::res_word_t res1
);

  localparam int LBW = $clog2(LENGTH_BYTES_MAX + 1);

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_LENGTH  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_IGNORE  = 2'd3;

  logic [7:0]     max_fields;
  logic [1:0]     phase,        phase_next;
  logic [LBW-1:0] len_left,     len_left_next;
  logic [15:0]    len_acc,      len_acc_next;
  logic [15:0]    payload_left, payload_left_next;
  logic [15:0]    stream_pos,   stream_pos_next;
  logic [15:0]    item_start,   item_start_next;
  logic [1:0]     kind_held,    kind_held_next;
  logic [1:0]     header_size,  header_size_next;
  logic [7:0]     items_seen,   items_seen_next;
  logic           error_seen,   error_seen_next;

  logic step;

  assign step     = head_valid && room;
  assign head_pop = step;

  always_comb begin
    logic        have_res;
    logic        do_rec;
    logic        do_err;
    logic [15:0] rec_len;
    logic [1:0]  rec_off;
    logic [7:0]  items_inc;
    rlp_pkg::res_word_t first;
    rlp_pkg::res_word_t summ;

    phase_next        = phase;
    len_left_next     = len_left;
    len_acc_next      = len_acc;
    payload_left_next = payload_left;
    item_start_next   = item_start;
    kind_held_next    = kind_held;
    header_size_next  = header_size;
    items_seen_next   = items_seen;
    error_seen_next   = error_seen;
    stream_pos_next   = (stream_pos != 16'hFFFF) ? stream_pos + 16'd1 : stream_pos;
    do_rec    = 1'b0;
    do_err    = 1'b0;
    rec_len   = '0;
    rec_off   = '0;
    items_inc = items_seen + 8'd1;

    unique case (phase)
      PH_HEADER: begin
        if (error_seen || items_seen >= max_fields) begin
          phase_next = PH_IGNORE;
        end else begin
          item_start_next = stream_pos;
          unique case (head.hclass)
            rlp_pkg::CL_SINGLE: begin
              kind_held_next = rlp_pkg::KIND_BYTE;
              do_rec = 1'b1;
            end
            rlp_pkg::CL_SHORT_STR, rlp_pkg::CL_SHORT_LIST: begin
              kind_held_next = (head.hclass == rlp_pkg::CL_SHORT_STR) ?
                               rlp_pkg::KIND_STRING : rlp_pkg::KIND_LIST;
              do_rec  = 1'b1;
              rec_len = 16'(head.short_len);
              rec_off = 2'd1;
            end
            default: begin
              kind_held_next = (head.hclass == rlp_pkg::CL_LONG_STR) ?
                               rlp_pkg::KIND_STRING : rlp_pkg::KIND_LIST;
              if (head.too_long) begin
                do_err = 1'b1;
              end else begin
                len_left_next    = head.len_bytes[LBW-1:0];
                header_size_next = head.len_bytes[1:0] + 2'd1;
                len_acc_next     = '0;
                phase_next       = PH_LENGTH;
              end
            end
          endcase
        end
      end
      PH_LENGTH: begin
        // A value above one byte cannot take another byte within 16 bits.
        if (len_acc > 16'h00FF) begin
          do_err = 1'b1;
        end else begin
          len_acc_next  = {len_acc[7:0], head.data_byte};
          len_left_next = (len_left != '0) ? len_left - 1'b1 : len_left;
          if (len_left_next == '0) begin
            do_rec  = 1'b1;
            rec_len = len_acc_next;
            rec_off = header_size;
          end
        end
      end
      PH_PAYLOAD: begin
        payload_left_next = (payload_left != '0) ? payload_left - 16'd1 : payload_left;
        if (payload_left_next == '0) begin
          phase_next = PH_HEADER;
        end
      end
      default: begin
      end
    endcase

    first = '0;
    if (do_err) begin
      error_seen_next   = 1'b1;
      phase_next        = PH_IGNORE;
      first.status      = rlp_pkg::ST_ERROR;
      first.item_kind   = kind_held_next;
      first.field_start = item_start_next;
      first.field_count = items_seen;
    end
    if (do_rec) begin
      items_seen_next    = items_inc;
      first.status       = rlp_pkg::ST_RECORD;
      first.item_kind    = kind_held_next;
      first.value_length = rec_len;
      first.value_offset = rec_off;
      first.field_start  = item_start_next;
      first.field_count  = items_inc;
      if (items_inc >= max_fields) begin
        phase_next = PH_IGNORE;
      end else if (rec_len == '0) begin
        phase_next = PH_HEADER;
      end else begin
        payload_left_next = rec_len;
        phase_next        = PH_PAYLOAD;
      end
    end
    have_res = do_err || do_rec;

    summ             = '0;
    summ.status      = rlp_pkg::ST_SUMMARY;
    summ.field_count = items_seen_next;
    summ.last_of_run = 1'b1;

    // The summary always closes the run, so it goes second when both exist.
    res0 = have_res ? first : summ;
    res1 = summ;
    res0.last_of_run = !(have_res && head.last_byte);
    wr.wr0 = step && (have_res || head.last_byte);
    wr.wr1 = step && have_res && head.last_byte;

    if (head.last_byte) begin
      phase_next        = PH_HEADER;
      len_left_next     = '0;
      len_acc_next      = '0;
      payload_left_next = '0;
      stream_pos_next   = '0;
      item_start_next   = '0;
      kind_held_next    = '0;
      header_size_next  = '0;
      items_seen_next   = '0;
      error_seen_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_fields <= rlp_pkg::BYTE_MAX;
    end else if (cfg_we) begin
      max_fields <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      len_left     <= '0;
      len_acc      <= '0;
      payload_left <= '0;
      stream_pos   <= '0;
      item_start   <= '0;
      kind_held    <= '0;
      header_size  <= '0;
      items_seen   <= '0;
      error_seen   <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      len_left     <= len_left_next;
      len_acc      <= len_acc_next;
      payload_left <= payload_left_next;
      stream_pos   <= stream_pos_next;
      item_start   <= item_start_next;
      kind_held    <= kind_held_next;
      header_size  <= header_size_next;
      items_seen   <= items_seen_next;
      error_seen   <= error_seen_next;
    end
  end

endmodule

// ===== src/rlp_res_queue.sv =====
// Result queue: takes up to two result words a cycle and hands out one.
`timescale 1ns / 1ps

module rlp_res_queue (
  input  logic               clk,
  input  logic               rst,
  input  rlp_pkg::res_wr_t   wr,
  input  rlp_pkg::res_word_t res0,
  input  rlp_pkg::res_word_t res1,
  output logic               room,
  output rlp_pkg::res_word_t result,
  output logic               empty,
  input  logic               pop
);

  localparam int DEPTH = rlp_pkg::RES_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  rlp_pkg::res_word_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic pop_ok;

  // Room for a full run of two words, so the back never has to split one.
  assign room   = (count <= CNT_W'(DEPTH - 2));
  assign empty  = (count == '0);
  assign pop_ok = pop && !empty;
  assign result = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr.wr0) begin
      mem[wr_ptr] <= res0;
    end
    if (wr.wr1) begin
      mem[wr_ptr + 1'b1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(wr.wr0) + PTR_W'(wr.wr1);
      if (pop_ok) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(wr.wr0) + CNT_W'(wr.wr1) - CNT_W'(pop_ok);
    end
  end

endmodule

// ===== src/rlp_header_stream_parser_unit.sv =====
// Top level of the RLP header stream parser: front, back and result queue.
//
//   channel  | direction | handshake           | word
//   ---------+-----------+---------------------+-----------------------------
//   item     | in        | push / full         | data_byte, last_byte
//   result   | out       | pop / empty         | status .. last_of_run
//   cfg      | in        | cfg_we              | cfg_data (max_fields)
//
// One byte is taken per cycle while full is low; the parser retires one byte per
// cycle while the result queue has room. A byte's first result word passes the
// byte queue, then the result queue, before it can be popped, and the parser can
// stall between them; the last byte of a stream can give two result words, which
// leave one per cycle through the result port while pop is held.
// Reset is synchronous and empties both queues; max_fields returns to 255.
// A stalled result port fills the result queue, which stops the parser, and
// the byte queue then raises full.
`timescale 1ns / 1ps

module rlp_header_stream_parser_unit #(
  parameter int LENGTH_BYTES_MAX = rlp_pkg::LEN_BYTES_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  rlp_pkg::in_word_t  item,
  output logic               empty,
  input  logic               pop,
  output rlp_pkg::res_word_t result,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data
);

  rlp_pkg::hdr_t      head;
  logic               head_valid;
  logic               head_pop;
  logic               room;
  rlp_pkg::res_wr_t   wr;
  rlp_pkg::res_word_t res0;
  rlp_pkg::res_word_t res1;

  rlp_front #(
    .LENGTH_BYTES_MAX(LENGTH_BYTES_MAX)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .head      (head),
    .head_valid(head_valid),
    .head_pop  (head_pop)
  );

  rlp_back #(
    .LENGTH_BYTES_MAX(LENGTH_BYTES_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .head      (head),
    .head_valid(head_valid),
    .head_pop  (head_pop),
    .room      (room),
    .wr        (wr),
    .res0      (res0),
    .res1      (res1)
  );

  rlp_res_queue u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .res0  (res0),
    .res1  (res1),
    .room  (room),
    .result(result),
    .empty (empty),
    .pop   (pop)
  );

endmodule
